// ===== hdl/hec_pkg.sv =====
// ----------------------------------------------------------------------------
// hec_pkg - shared types and helpers for the Hamming encode/check core
// Holds the transaction types, command codes, parity group masks and the
// parity bit count lookup used by the input stage, datapath and top level.
// ----------------------------------------------------------------------------
package hec_pkg;

  localparam int WORD_BITS     = 63;  // codeword positions 1..63
  localparam int CNT_W         = 6;   // bit_count / code_len width
  localparam int LEN_W         = 7;   // n + r before the range check
  localparam int R_W           = 3;   // parity bit count, at most 7
  localparam int N_GROUPS      = 6;   // parity groups covering 63 positions
  localparam int MAX_CODE_BITS = 63;  // longest codeword that encode may emit

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  typedef logic [WORD_BITS-1:0] word_t;

  // One input transaction
  typedef struct packed {
    cmd_t             cmd;
    word_t            bit_word;
    logic [CNT_W-1:0] bit_count;
  } item_t;

  // One result transaction
  typedef struct packed {
    word_t            codeword;
    logic [CNT_W-1:0] code_len;
    logic             parity_ok;
    logic             bad_length;
  } result_t;

  // Positions (bit k = position k+1) whose index has bit grp set
  function automatic word_t group_mask(input int unsigned grp);
    word_t m;
    m = '0;
    for (int unsigned p = 1; p <= WORD_BITS; p++) begin
      if (((p >> grp) & 1) != 0) begin
        m[CNT_W'(p - 1)] = 1'b1;
      end
    end
    return m;
  endfunction

  // Place data bits LSB first on the positions that are not powers of two
  function automatic word_t scatter_data(input word_t d);
    word_t       cw;
    int unsigned j;
    cw = '0;
    j  = 0;
    for (int unsigned p = 1; p <= WORD_BITS; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[CNT_W'(p - 1)] = d[CNT_W'(j)];
        j++;
      end
    end
    return cw;
  endfunction

  // Smallest r with 2^r >= n + r + 1
  function automatic logic [R_W-1:0] parity_count(input logic [CNT_W-1:0] n);
    logic [R_W-1:0] r;
    if (n == '0)                 r = R_W'(0);
    else if (n == CNT_W'(1))     r = R_W'(2);
    else if (n <= CNT_W'(4))     r = R_W'(3);
    else if (n <= CNT_W'(11))    r = R_W'(4);
    else if (n <= CNT_W'(26))    r = R_W'(5);
    else if (n <= CNT_W'(57))    r = R_W'(6);
    else                         r = R_W'(7);
    return r;
  endfunction

endpackage

// ===== hdl/hec_in_reg.sv =====
// ----------------------------------------------------------------------------
// hec_in_reg - input register stage
// Captures one transaction per cycle and holds it while the result
// register downstream is full and stalled.
// ----------------------------------------------------------------------------
module hec_in_reg import hec_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  item_t  in_item,
  input  logic   advance,     // result register takes a new transaction
  output logic   s1_valid,
  output item_t  s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Load when empty or when the held transaction moves on this cycle
  assign load     = advance || !valid_r;
  assign in_stall = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hdl/hec_datapath.sv =====
// ----------------------------------------------------------------------------
// hec_datapath - encode and check logic
// Masks the word to bit_count, scatters data for encode, and runs six
// parity XOR trees shared by both commands.
// ----------------------------------------------------------------------------
module hec_datapath import hec_pkg::*; (
  input  item_t   item,
  output result_t result
);

  word_t              len_mask;
  word_t              masked;
  word_t              data_cw;
  word_t              tree_src;
  word_t              enc_cw;
  logic [N_GROUPS-1:0] par;
  logic [R_W-1:0]     r;
  logic [LEN_W-1:0]   len;
  logic               too_long;

  // Drop bits above bit_count
  assign len_mask = ~({WORD_BITS{1'b1}} << item.bit_count);
  assign masked   = item.bit_word & len_mask;

  // Spread data over the non power-of-two positions
  assign data_cw  = scatter_data(masked);

  // Share the group trees between encode and check
  assign tree_src = (item.cmd == CMD_CHECK) ? masked : data_cw;

  for (genvar g = 0; g < N_GROUPS; g++) begin : g_group
    localparam word_t GMASK = group_mask(g);
    assign par[g] = ^(tree_src & GMASK);
  end

  // Insert parity bits at positions 1, 2, 4, ... 32
  always_comb begin
    enc_cw = data_cw;
    for (int g = 0; g < N_GROUPS; g++) begin
      enc_cw[CNT_W'((1 << g) - 1)] = par[g];
    end
  end

  // Codeword length and range check
  assign r        = parity_count(item.bit_count);
  assign len      = LEN_W'(item.bit_count) + LEN_W'(r);
  assign too_long = len > LEN_W'(MAX_CODE_BITS);

  // Select result fields
  always_comb begin
    result = '0;
    case (item.cmd)
      CMD_ENCODE: begin
        if (too_long) begin
          result.bad_length = 1'b1;
        end else begin
          result.codeword  = enc_cw;
          result.code_len  = len[CNT_W-1:0];
          result.parity_ok = 1'b1;
        end
      end
      CMD_CHECK: begin
        result.parity_ok = ~|par;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ===== hdl/hamming_encode_and_check_core.sv =====
// ----------------------------------------------------------------------------
// hamming_encode_and_check_core - even parity Hamming encoder and checker
// Encodes up to 57 data bits into a codeword of up to 63 bits, or tests
// all parity groups of a received codeword, one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one transaction every clock cycle while in_stall is low: the input
// register feeds a single pass of mask, scatter and six parity XOR trees,
// which loads the result register. in_stall rises only when both registers
// are full and out_stall is high, so one more transaction is taken while a
// finished result waits. Bit k of a word is codeword position k+1. Encode
// with more than 57 data bits reports bad_length with zero codeword; check
// reports parity_ok and corrects nothing.
module hamming_encode_and_check_core import hec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [WORD_BITS-1:0] in_bit_word,
  input  logic [CNT_W-1:0]     in_bit_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_codeword,
  output logic [CNT_W-1:0]     out_code_len,
  output logic                 out_parity_ok,
  output logic                 out_bad_length
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  result_t s1_result;
  logic    advance;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  assign in_item.cmd       = cmd_t'(in_cmd);
  assign in_item.bit_word  = in_bit_word;
  assign in_item.bit_count = in_bit_count;

  // Advance the pipe when the result register is empty or drained
  assign advance = !out_valid_r || !out_stall;

  hec_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  hec_datapath u_datapath (
    .item   (s1_item),
    .result (s1_result)
  );

  assign out_valid_nxt = advance ? s1_valid : out_valid_r;

  // Hold result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_r <= s1_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_codeword   = out_r.codeword;
  assign out_code_len   = out_r.code_len;
  assign out_parity_ok  = out_r.parity_ok;
  assign out_bad_length = out_r.bad_length;

  // Syndrome of the delivered codeword, for checking encode results
  logic [N_GROUPS-1:0] out_syn;
  for (genvar g = 0; g < N_GROUPS; g++) begin : g_syn
    localparam word_t GMASK = group_mask(g);
    assign out_syn[g] = ^(out_r.codeword & GMASK);
  end

  // Encode results must be valid codewords
  a_enc_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.code_len != '0) |-> (out_syn == '0))
    else $error("encoded codeword has nonzero syndrome");

  // Length overflow zeroes the other fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad_length) |->
      (out_r.codeword == '0 && out_r.code_len == '0 && !out_r.parity_ok))
    else $error("bad_length result carries nonzero fields");

  // A codeword length only comes with a good encode
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.code_len != '0) |-> (out_r.parity_ok && !out_r.bad_length))
    else $error("code_len set on a failing result");

  // A held transaction in the input register is not lost while stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid_r && out_stall) |=> s1_valid)
    else $error("input stage dropped a stalled transaction");

endmodule
